@@ design/cba_pkg.sv @@
// shared types and constants for the contiguous block allocator
// no dependencies; imported by cba_ctrl, contiguous_block_allocator and tb_top
`default_nettype none

package cba_pkg;

  // default geometry
  localparam int CBA_NUM_SLOTS   = 8;
  localparam int CBA_NUM_BLOCKS  = 8;
  localparam int CBA_BLOCK_BYTES = 4;

  // fixed field widths of the stream beats
  localparam int BYTES_W   = 8;
  localparam int SLOT_IN_W = 4;
  localparam int OUT_IDX_W = 3;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cba_cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_NO_SLOT  = 3'd3,
    ST_BAD_SLOT = 3'd4
  } cba_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BSCAN,
    S_SSCAN,
    S_FREE,
    S_DONE
  } cba_state_t;

  // one finished result handed from the controller to the output register
  typedef struct packed {
    logic [OUT_IDX_W-1:0] first_block;
    logic [OUT_IDX_W-1:0] slot_given;
    cba_status_t          status;
  } cba_result_t;

endpackage

`default_nettype wire

@@ design/cba_ram.sv @@
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module cba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/cba_ctrl.sv @@
// request sequencer: size check, first-fit block scan, slot scan and free
// depends on cba_pkg and cba_ram (slot table holding start block and block count)
`default_nettype none

module cba_ctrl
  import cba_pkg::*;
#(
  parameter int NUM_SLOTS   = CBA_NUM_SLOTS,
  parameter int NUM_BLOCKS  = CBA_NUM_BLOCKS,
  parameter int BLOCK_BYTES = CBA_BLOCK_BYTES
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire cba_cmd_t             req_cmd,
  input  wire logic [BYTES_W-1:0]   req_bytes,
  input  wire logic [SLOT_IN_W-1:0] req_slot,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output cba_result_t               res
);

  localparam int SW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int BW   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int RW   = $clog2(NUM_BLOCKS + 1);
  localparam int MAXB = NUM_BLOCKS * BLOCK_BYTES;
  localparam int RBW  = $clog2(MAXB + 1);
  localparam int CW   = (RBW > BYTES_W) ? RBW : BYTES_W;
  localparam int DW   = BW + RW;

  cba_state_t           state_r, state_nxt;
  logic [BYTES_W-1:0]   bytes_r, bytes_nxt;
  logic [NUM_BLOCKS-1:0] free_map_r, free_map_nxt;
  logic [NUM_SLOTS-1:0] used_r, used_nxt;
  logic [BW-1:0]        bcnt_r, bcnt_nxt;
  logic [RW-1:0]        run_r, run_nxt;
  logic [RBW-1:0]       rbytes_r, rbytes_nxt;
  logic [SW-1:0]        scnt_r, scnt_nxt;
  logic [SW-1:0]        fslot_r, fslot_nxt;
  logic [BW-1:0]        start_r, start_nxt;
  logic [RW-1:0]        need_r, need_nxt;
  cba_result_t          res_r, res_nxt;

  logic                 accept;
  logic [6:0]           slot_wide;
  logic [SW-1:0]        slot_idx;
  logic                 slot_valid;
  logic                 size_bad;
  logic                 blk_free;
  logic [RBW-1:0]       rb_sum;
  logic                 run_found;
  logic                 blk_last;
  logic                 slot_open;
  logic                 slot_last;
  logic                 ram_we;
  logic [DW-1:0]        ram_wdata;
  logic [DW-1:0]        ram_rdata;
  logic [BW-1:0]        rd_start;
  logic [RW-1:0]        rd_need;

  // blocks start .. start+need-1 as a bit mask
  function automatic logic [NUM_BLOCKS-1:0] range_mask(input logic [BW-1:0] start,
                                                       input logic [RW-1:0] need);
    logic [NUM_BLOCKS-1:0] m;
    logic [7:0]            lim;
    lim = 8'(start) + 8'(need);
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      m[b] = (8'(b) >= 8'(start)) && (8'(b) < lim);
    end
    return m;
  endfunction

  // slot table: start block and block count per slot
  cba_ram #(
    .WIDTH(DW),
    .DEPTH(NUM_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(scnt_r),
    .wdata(ram_wdata),
    .raddr(slot_idx),
    .rdata(ram_rdata)
  );

  // request decode
  assign accept     = req_valid && req_ready;
  assign slot_wide  = 7'(req_slot);
  assign slot_idx   = SW'(req_slot);
  assign slot_valid = (slot_wide < 7'(NUM_SLOTS)) && used_r[slot_idx];
  assign size_bad   = (req_bytes == '0) || (CW'(req_bytes) > CW'(MAXB));

  // block scan step
  assign blk_free  = free_map_r[bcnt_r];
  assign rb_sum    = rbytes_r + RBW'(BLOCK_BYTES);
  assign run_found = blk_free && (CW'(rb_sum) >= CW'(bytes_r));
  assign blk_last  = (bcnt_r == BW'(NUM_BLOCKS - 1));

  // slot scan step
  assign slot_open = !used_r[scnt_r];
  assign slot_last = (scnt_r == SW'(NUM_SLOTS - 1));

  // slot table write on allocation, read data for a free
  assign ram_we    = (state_r == S_SSCAN) && slot_open;
  assign ram_wdata = {start_r, need_r};
  assign rd_start  = ram_rdata[DW-1:RW];
  assign rd_need   = ram_rdata[RW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (req_cmd == CMD_ALLOC) begin
            state_nxt = size_bad ? S_DONE : S_BSCAN;
          end else begin
            state_nxt = slot_valid ? S_FREE : S_DONE;
          end
        end
      end
      S_BSCAN: begin
        if (run_found) begin
          state_nxt = S_SSCAN;
        end else if (blk_last) begin
          state_nxt = S_DONE;
        end
      end
      S_SSCAN: begin
        if (slot_open || slot_last) begin
          state_nxt = S_DONE;
        end
      end
      S_FREE: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and map updates
  always_comb begin
    bytes_nxt    = bytes_r;
    free_map_nxt = free_map_r;
    used_nxt     = used_r;
    bcnt_nxt     = bcnt_r;
    run_nxt      = run_r;
    rbytes_nxt   = rbytes_r;
    scnt_nxt     = scnt_r;
    fslot_nxt    = fslot_r;
    start_nxt    = start_r;
    need_nxt     = need_r;
    res_nxt      = res_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          bytes_nxt  = req_bytes;
          fslot_nxt  = slot_idx;
          bcnt_nxt   = '0;
          run_nxt    = '0;
          rbytes_nxt = '0;
          scnt_nxt   = '0;
          res_nxt    = '{first_block: '0, slot_given: '0, status: ST_OK};
          if (req_cmd == CMD_ALLOC) begin
            if (size_bad) begin
              res_nxt.status = ST_BAD_SIZE;
            end
          end else if (!slot_valid) begin
            res_nxt.status = ST_BAD_SLOT;
          end
        end
      end
      S_BSCAN: begin
        // run length in blocks and in bytes ending at the current block
        run_nxt    = blk_free ? run_r + RW'(1) : '0;
        rbytes_nxt = blk_free ? rb_sum : '0;
        bcnt_nxt   = bcnt_r + BW'(1);
        if (run_found) begin
          start_nxt = bcnt_r - BW'(run_r);
          need_nxt  = run_r + RW'(1);
        end else if (blk_last) begin
          res_nxt.status = ST_NO_SPACE;
        end
      end
      S_SSCAN: begin
        scnt_nxt = scnt_r + SW'(1);
        if (slot_open) begin
          used_nxt[scnt_r]    = 1'b1;
          free_map_nxt        = free_map_r & ~range_mask(start_r, need_r);
          res_nxt.slot_given  = OUT_IDX_W'(scnt_r);
          res_nxt.first_block = OUT_IDX_W'(start_r);
        end else if (slot_last) begin
          res_nxt.status = ST_NO_SLOT;
        end
      end
      S_FREE: begin
        used_nxt[fslot_r]   = 1'b0;
        free_map_nxt        = free_map_r | range_mask(rd_start, rd_need);
        res_nxt.slot_given  = OUT_IDX_W'(fslot_r);
        res_nxt.first_block = OUT_IDX_W'(rd_start);
      end
      default: begin
      end
    endcase
  end

  // handshake outputs
  always_comb begin
    req_ready = (state_r == S_IDLE);
    res_valid = (state_r == S_DONE);
    res       = res_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      free_map_r <= {NUM_BLOCKS{1'b1}};
      used_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      free_map_r <= free_map_nxt;
      used_r     <= used_nxt;
    end
  end

  // scan counters and payload
  always_ff @(posedge clk) begin
    bytes_r  <= bytes_nxt;
    bcnt_r   <= bcnt_nxt;
    run_r    <= run_nxt;
    rbytes_r <= rbytes_nxt;
    scnt_r   <= scnt_nxt;
    fslot_r  <= fslot_nxt;
    start_r  <= start_nxt;
    need_r   <= need_nxt;
    res_r    <= res_nxt;
  end

endmodule

`default_nettype wire

@@ design/contiguous_block_allocator.sv @@
// First-fit contiguous block allocator, top level.
// Depends on cba_pkg and cba_ctrl.
//
// Input beats carry one request: in_tuser selects allocate (0) or free (1),
// in_tdata holds the byte size and the slot to release. Every request gives
// exactly one output beat with a status, the slot and the first block.
// An allocate rounds the size up to whole blocks, scans the free map one
// block per cycle for the first run that fits, then scans the slot table
// one slot per cycle for the lowest empty slot. A rejected size or slot goes
// straight to its result, a free of a live slot reads the slot table and
// then releases its blocks, and an allocate lasts as long as its two
// scans.
// One request is worked on at a time; in_tready rises again as a result
// moves into the output register, so a new request is taken
// while that result still waits on out_tready.
// Reset (rst_n low, synchronous) marks every block free and every slot
// empty. A stall on out_tready holds the output beat and, once the
// controller has a second result ready, holds off new requests.
`default_nettype none

module contiguous_block_allocator
  import cba_pkg::*;
#(
  parameter int NUM_SLOTS   = CBA_NUM_SLOTS,
  parameter int NUM_BLOCKS  = CBA_NUM_BLOCKS,
  parameter int BLOCK_BYTES = CBA_BLOCK_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // file_bytes[7:0], slot_to_free[11:8], zeros
  input  wire logic [0:0]  in_tuser,   // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // status[2:0], slot_given[5:3], first_block[8:6], zeros
);

  logic        res_valid;
  logic        res_ready;
  cba_result_t res;
  logic        out_valid_r, out_valid_nxt;
  cba_result_t out_res_r, out_res_nxt;

  // request sequencer with the slot table and the free map
  cba_ctrl #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(in_tvalid),
    .req_ready(in_tready),
    .req_cmd  (cba_cmd_t'(in_tuser)),
    .req_bytes(in_tdata[BYTES_W-1:0]),
    .req_slot (in_tdata[BYTES_W+SLOT_IN_W-1:BYTES_W]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // output register loads when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  // output beat
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_res_r.first_block, out_res_r.slot_given,
                       out_res_r.status};

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for contiguous_block_allocator: directed and random requests
// with a scoreboard class that predicts every result. Depends on cba_pkg and the RTL.

module tb_top;
  import cba_pkg::*;

  localparam int NSLOT = CBA_NUM_SLOTS;
  localparam int NBLK  = CBA_NUM_BLOCKS;
  localparam int BBYTE = CBA_BLOCK_BYTES;
  localparam int RANDOM_PER_PHASE = 417;
  localparam int SETTLE_CYCLES = NBLK + NSLOT + 4;

  // tracks the allocator's free map and slot table, queues predicted results
  class alloc_scoreboard;
    logic [NBLK-1:0] free_map;
    logic [7:0]      slot_bytes [NSLOT];
    logic [2:0]      slot_first [NSLOT];
    cba_result_t     pending_results [$];
    int              errors;
    int              beats_checked;
    int              status_seen [8];

    function new();
      free_map = '1;
      for (int s = 0; s < NSLOT; s++) begin
        slot_bytes[s] = '0;
        slot_first[s] = '0;
      end
      errors = 0;
      beats_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int blocks_needed(int nbytes);
      return (nbytes + BBYTE - 1) / BBYTE;
    endfunction

    function logic [NBLK-1:0] run_bits(int first, int count);
      logic [NBLK-1:0] m;
      m = '0;
      for (int i = 0; i < count; i++)
        if (first + i < NBLK) m[first + i] = 1'b1;
      return m;
    endfunction

    // apply one accepted request to the shadow state and queue its result
    function void note_request(cba_cmd_t cmd, logic [7:0] nbytes, logic [3:0] fslot);
      cba_result_t r;
      int need;
      int first;
      int s;
      bit found;
      r = '{first_block: '0, slot_given: '0, status: ST_OK};
      if (cmd == CMD_ALLOC) begin
        found = 1'b0;
        first = 0;
        s = 0;
        if (nbytes == 0 || int'(nbytes) > NBLK * BBYTE) begin
          r.status = ST_BAD_SIZE;
        end else begin
          need = blocks_needed(int'(nbytes));
          // first fit: lowest run of free blocks that is long enough
          for (first = 0; first + need <= NBLK; first++) begin
            if ((free_map & run_bits(first, need)) == run_bits(first, need)) begin
              found = 1'b1;
              break;
            end
          end
          if (!found) begin
            r.status = ST_NO_SPACE;
          end else begin
            for (s = 0; s < NSLOT; s++)
              if (slot_bytes[s] == 0) break;
            if (s >= NSLOT) begin
              r.status = ST_NO_SLOT;
            end else begin
              slot_bytes[s] = nbytes;
              slot_first[s] = first[2:0];
              free_map &= ~run_bits(first, need);
              r.slot_given = s[2:0];
              r.first_block = first[2:0];
            end
          end
        end
      end else begin
        if (int'(fslot) >= NSLOT || slot_bytes[fslot] == 0) begin
          r.status = ST_BAD_SLOT;
        end else begin
          free_map |= run_bits(int'(slot_first[fslot]),
                               blocks_needed(int'(slot_bytes[fslot])));
          r.slot_given = fslot[2:0];
          r.first_block = slot_first[fslot];
          slot_bytes[fslot] = '0;
          slot_first[fslot] = '0;
        end
      end
      pending_results.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // compare one output beat with the oldest predicted result
    task check_result(logic [15:0] beat);
      cba_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result beat %h", beat));
        return;
      end
      want = pending_results.pop_front();
      beats_checked++;
      status_seen[want.status]++;
      if (beat[2:0] !== want.status)
        report($sformatf("status %0d, expected %0d", beat[2:0], want.status));
      if (beat[5:3] !== want.slot_given)
        report($sformatf("slot_given %0d, expected %0d", beat[5:3], want.slot_given));
      if (beat[8:6] !== want.first_block)
        report($sformatf("first_block %0d, expected %0d", beat[8:6], want.first_block));
      if (beat[15:9] !== '0)
        report($sformatf("padding bits %h not zero", beat[15:9]));
    endtask

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  int send_idle_pct = 25;
  int recv_stall_pct = 56;
  int requests_sent = 0;

  alloc_scoreboard sb = new();

  contiguous_block_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // present one request beat, with random idle cycles ahead of it
  task automatic send_request(cba_cmd_t cmd, logic [7:0] nbytes, logic [3:0] fslot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0000, fslot, nbytes};
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, nbytes, fslot);
    requests_sent++;
  endtask

  // hold off the sender until every predicted result has come back
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // random request: mostly valid sizes and frees of live slots
  task automatic send_random_request();
    int occupied [$];
    int r;
    logic [7:0] nbytes;
    logic [3:0] fslot;
    r = int'($urandom_range(99));
    nbytes = 8'($urandom_range(255));
    fslot = 4'($urandom_range(15));
    if (r < 50) begin
      r = int'($urandom_range(99));
      if (r < 45) nbytes = 8'($urandom_range(1, 12));
      else if (r < 85) nbytes = 8'($urandom_range(1, NBLK * BBYTE));
      else if (r < 90) nbytes = '0;
      send_request(CMD_ALLOC, nbytes, fslot);
    end else begin
      for (int s = 0; s < NSLOT; s++)
        if (sb.slot_bytes[s] != 0) occupied.push_back(s);
      if (occupied.size() != 0 && $urandom_range(99) < 75)
        fslot = 4'(occupied[$urandom_range(occupied.size() - 1)]);
      send_request(CMD_FREE, nbytes, fslot);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: size limits, bad slots, full map, fragmentation
    send_request(CMD_ALLOC, 8'd0,   4'd5);
    send_request(CMD_ALLOC, 8'd33,  4'd0);
    send_request(CMD_ALLOC, 8'd255, 4'd15);
    send_request(CMD_FREE,  8'd255, 4'd15);
    send_request(CMD_FREE,  8'd0,   4'd0);
    send_request(CMD_ALLOC, 8'd32,  4'd0);
    send_request(CMD_ALLOC, 8'd1,   4'd0);
    send_request(CMD_FREE,  8'd0,   4'd0);
    send_request(CMD_ALLOC, 8'd1,   4'd0);
    send_request(CMD_ALLOC, 8'd4,   4'd0);
    send_request(CMD_ALLOC, 8'd5,   4'd0);
    send_request(CMD_ALLOC, 8'd9,   4'd0);
    send_request(CMD_FREE,  8'd0,   4'd1);
    send_request(CMD_ALLOC, 8'd8,   4'd0);
    send_request(CMD_ALLOC, 8'd2,   4'd0);
    send_request(CMD_ALLOC, 8'd3,   4'd0);
    send_request(CMD_FREE,  8'd0,   4'd8);
    send_request(CMD_FREE,  8'd0,   4'd2);
    send_request(CMD_ALLOC, 8'd8,   4'd0);
    for (int s = 0; s < 5; s++) send_request(CMD_FREE, 8'd0, s[3:0]);
    wait_results_drained();

    // random phases with different idle patterns
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 25; recv_stall_pct = 56; end
        1: begin send_idle_pct = 56; recv_stall_pct = 25; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_request();
      wait_results_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests, %0d results checked", requests_sent, sb.beats_checked);
    $display("status mix: ok %0d, bad size %0d, no space %0d, no slot %0d, bad slot %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_BAD_SIZE],
             sb.status_seen[ST_NO_SPACE], sb.status_seen[ST_NO_SLOT],
             sb.status_seen[ST_BAD_SLOT]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ contiguous_block_allocator.f @@
design/cba_pkg.sv
design/cba_ram.sv
design/cba_ctrl.sv
design/contiguous_block_allocator.sv
bench/tb_top.sv
